### hdl/shapt_pkg.sv
// Shared types, constants and helpers of the string hash unit.
// No dependencies; imported by shapt_dp, shapt_ctrl, the top level and the simulation files.
package shapt_pkg;

  // Rotation amounts of the add-rotate-xor mix (all rotate right).
  localparam int unsigned ROT_A = 14;
  localparam int unsigned ROT_B = 11;
  localparam int unsigned ROT_H = 25;

  // Chunk and tail geometry.
  localparam int unsigned CHUNK_BYTES = 12;
  localparam int unsigned TAIL_DEPTH  = 31;
  localparam logic [31:0] PREFIX_MIN  = 32'd32;
  localparam logic [3:0]  CHUNK_LAST  = 4'(CHUNK_BYTES - 1);
  localparam logic [4:0]  TAIL_FULL   = 5'(TAIL_DEPTH);

  // Shift amounts of the tail fold.
  localparam int unsigned FOLD_SHL = 5;
  localparam int unsigned FOLD_SHR = 2;

  // Steps of the chunk absorb sequence.
  typedef enum logic [1:0] {
    AB_ADD,
    AB_MIX_A,
    AB_MIX_B,
    AB_MIX_H
  } absorb_step_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         take;       // input request accepted this cycle
    logic         absorb;     // run one absorb step
    absorb_step_e step;       // which absorb step
    logic         fold;       // fold one tail byte into h
    logic         emit_zero;  // load the result register with zero
    logic         emit_h;     // load the result register with h
  } cmd_t;

  // Status from the datapath to the controller, about the offered request.
  typedef struct packed {
    logic empty;       // start of an empty string
    logic ignore;      // byte outside any string
    logic chunk_done;  // byte completes a 12-byte chunk
    logic last;        // byte is the last of its string
    logic tail_empty;  // no tail bytes left to fold
  } sts_t;

  // Rotate right by a constant amount.
  function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned s);
    logic [63:0] dbl;
    dbl = {x, x} >> s;
    return dbl[31:0];
  endfunction

endpackage

### hdl/shapt_ifs.sv
// Handshake channels of the string hash unit: request and result.
// No dependencies.
interface shapt_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] string_length;
  logic        start_of_string;

  modport source (output valid, data_byte, string_length, start_of_string, input ready);
  modport sink   (input valid, data_byte, string_length, start_of_string, output ready);
endinterface

interface shapt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

### hdl/shapt_dp.sv
// Datapath of the string hash unit: mix state, byte stores, result register.
// Depends on shapt_pkg; driven by commands from shapt_ctrl.
module shapt_dp
  import shapt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] string_length_i,
  input  logic        start_of_string_i,
  output sts_t        sts_o,
  output logic [31:0] hash_o
);

  logic [31:0] a_q, a_d, b_q, b_d, h_q, h_d;
  logic [31:0] rem_q, rem_d;
  logic [3:0]  pos_q, pos_d;
  logic [4:0]  tc_q, tc_d;
  logic        in_string_q, in_string_d;
  logic [31:0] hash_q;

  logic [7:0]  chunk_q [CHUNK_BYTES];
  logic [7:0]  tail_q  [TAIL_DEPTH];

  logic [3:0]  pos_eff;
  logic [4:0]  tc_eff;
  logic [31:0] rem_eff;
  logic        empty, ignore, active, to_chunk, chunk_done, last;
  logic [31:0] w0, w1, w2;
  logic [7:0]  tail_rd;
  logic [4:0]  tail_idx;

  // A start request restarts the counters before the byte is placed.
  assign pos_eff    = start_of_string_i ? 4'd0 : pos_q;
  assign tc_eff     = start_of_string_i ? 5'd0 : tc_q;
  assign rem_eff    = start_of_string_i ? string_length_i : rem_q;
  assign empty      = start_of_string_i && (string_length_i == 32'd0);
  assign ignore     = !start_of_string_i && !in_string_q;
  assign active     = !ignore && !empty;
  assign to_chunk   = (pos_eff != 4'd0) || ((tc_eff == 5'd0) && (rem_eff >= PREFIX_MIN));
  assign chunk_done = to_chunk && (pos_eff == CHUNK_LAST);
  assign last       = (rem_eff == 32'd1);

  assign sts_o.empty      = empty;
  assign sts_o.ignore     = ignore;
  assign sts_o.chunk_done = chunk_done;
  assign sts_o.last       = last;
  assign sts_o.tail_empty = (tc_q == 5'd0);

  // Little-endian words of the stored chunk.
  assign w0 = {chunk_q[3], chunk_q[2], chunk_q[1], chunk_q[0]};
  assign w1 = {chunk_q[7], chunk_q[6], chunk_q[5], chunk_q[4]};
  assign w2 = {chunk_q[11], chunk_q[10], chunk_q[9], chunk_q[8]};

  // The fold walks the tail from its last byte back to the first.
  assign tail_idx = tc_q - 5'd1;
  assign tail_rd  = tail_q[tail_idx];

  // Next values of the mix state and counters.
  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    h_d         = h_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    tc_d        = tc_q;
    in_string_d = in_string_q;

    if (cmd_i.take) begin
      if (start_of_string_i) begin
        a_d         = 32'd0;
        b_d         = 32'd0;
        h_d         = string_length_i;
        in_string_d = (string_length_i != 32'd0);
      end
      pos_d = pos_eff;
      tc_d  = tc_eff;
      rem_d = rem_eff;
      if (active) begin
        if (to_chunk) begin
          pos_d = chunk_done ? 4'd0 : pos_eff + 4'd1;
        end else if (tc_eff < TAIL_FULL) begin
          tc_d = tc_eff + 5'd1;
        end
        rem_d = rem_eff - 32'd1;
        if (last) begin
          in_string_d = 1'b0;
        end
      end
    end

    // One add or one add-rotate-xor step per cycle.
    if (cmd_i.absorb) begin
      case (cmd_i.step)
        AB_ADD: begin
          a_d = a_q + w0;
          b_d = b_q + w1;
          h_d = h_q + w2;
        end
        AB_MIX_A: a_d = (a_q ^ h_q) - rotr32(h_q, ROT_A);
        AB_MIX_B: b_d = (b_q ^ a_q) - rotr32(a_q, ROT_B);
        AB_MIX_H: h_d = (h_q ^ b_q) - rotr32(b_q, ROT_H);
        default: ;
      endcase
    end

    if (cmd_i.fold) begin
      h_d  = h_q ^ ((h_q << FOLD_SHL) + (h_q >> FOLD_SHR) + {24'd0, tail_rd});
      tc_d = tc_q - 5'd1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q         <= 32'd0;
      b_q         <= 32'd0;
      h_q         <= 32'd0;
      rem_q       <= 32'd0;
      pos_q       <= 4'd0;
      tc_q        <= 5'd0;
      in_string_q <= 1'b0;
    end else begin
      a_q         <= a_d;
      b_q         <= b_d;
      h_q         <= h_d;
      rem_q       <= rem_d;
      pos_q       <= pos_d;
      tc_q        <= tc_d;
      in_string_q <= in_string_d;
    end
  end

  // Byte stores and result register carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && active) begin
      if (to_chunk) begin
        chunk_q[pos_eff] <= data_byte_i;
      end else if (tc_eff < TAIL_FULL) begin
        tail_q[tc_eff] <= data_byte_i;
      end
    end
    if (cmd_i.emit_zero) begin
      hash_q <= 32'd0;
    end else if (cmd_i.emit_h) begin
      hash_q <= h_q;
    end
  end

  assign hash_o = hash_q;

endmodule

### hdl/shapt_ctrl.sv
// Controller of the string hash unit: request intake, absorb sequence, tail fold.
// Depends on shapt_pkg; issues commands to shapt_dp and owns the result valid.
module shapt_ctrl
  import shapt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_ABSORB,
    ST_FOLD
  } state_e;

  state_e       state_q, state_d;
  absorb_step_e step_q, step_d;
  logic         pend_last_q, pend_last_d;
  logic         out_valid_q, out_valid_d;
  logic         accept;

  // Take a request only when the result slot is free or freeing.
  assign in_ready_o = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    pend_last_d = pend_last_q;
    cmd_o       = '0;
    cmd_o.step  = step_q;

    unique case (state_q)
      ST_RUN: begin
        if (accept) begin
          cmd_o.take = 1'b1;
          if (sts_i.empty) begin
            cmd_o.emit_zero = 1'b1;
          end else if (!sts_i.ignore) begin
            if (sts_i.chunk_done) begin
              state_d     = ST_ABSORB;
              step_d      = AB_ADD;
              pend_last_d = sts_i.last;
            end else if (sts_i.last) begin
              state_d = ST_FOLD;
            end
          end
        end
      end
      ST_ABSORB: begin
        cmd_o.absorb = 1'b1;
        unique case (step_q)
          AB_ADD:   step_d = AB_MIX_A;
          AB_MIX_A: step_d = AB_MIX_B;
          AB_MIX_B: step_d = AB_MIX_H;
          AB_MIX_H: state_d = pend_last_q ? ST_FOLD : ST_RUN;
          default:  state_d = ST_RUN;
        endcase
      end
      ST_FOLD: begin
        if (sts_i.tail_empty) begin
          cmd_o.emit_h = 1'b1;
          state_d      = ST_RUN;
        end else begin
          cmd_o.fold = 1'b1;
        end
      end
      default: state_d = ST_RUN;
    endcase

    out_valid_d = (cmd_o.emit_zero || cmd_o.emit_h) ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      step_q      <= AB_ADD;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/string_hash_arx_prefix_tail_unit.sv
// Top level of the string hash unit: one byte per request, one hash per completed string.
// Depends on shapt_pkg, shapt_ifs, shapt_ctrl and shapt_dp.
// Throughput: one byte per cycle; ARX mixing after the twelfth byte of a chunk, the tail
// fold and a stalled result hold intake off. After the last byte the tail bytes (0 to 31)
// are folded into h and h is loaded as the result; an empty string loads zero when taken.
// Reset: asynchronous, active low; clears mix state and control, byte stores keep garbage.
module string_hash_arx_prefix_tail_unit
  import shapt_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  shapt_in_if.sink       req_i,
  shapt_out_if.source    res_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing of intake, absorb and fold.
  shapt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Mix state, byte stores and result register.
  shapt_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .data_byte_i       (req_i.data_byte),
    .string_length_i   (req_i.string_length),
    .start_of_string_i (req_i.start_of_string),
    .sts_o             (sts),
    .hash_o            (res_o.hash_value)
  );

endmodule

### hdl/shapt_checker.sv
// Port-level checks of the string hash unit and the bind that attaches them.
// Depends on string_hash_arx_prefix_tail_unit and its channel interfaces.
module shapt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [31:0] string_length_i,
  input logic        start_of_string_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] hash_value_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A stalled result stays offered and unchanged.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(hash_value_i))
    else $error("result changed while stalled");

  // No request is taken while a result is stuck in the output register.
  a_no_take_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_acc)
    else $error("request accepted while result stalled");

  // An empty string yields hash zero in the next cycle.
  a_empty_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && start_of_string_i && (string_length_i == 32'd0)
      |=> out_valid_i && (hash_value_i == 32'd0))
    else $error("empty string result missing or nonzero");

  // The first byte of a string longer than one byte gives no result.
  a_no_early_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && start_of_string_i && (string_length_i > 32'd1) |=> !out_valid_i)
    else $error("result right after the start of a long string");

endmodule

bind string_hash_arx_prefix_tail_unit shapt_checker u_shapt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (req_i.valid),
  .in_ready_i        (req_i.ready),
  .string_length_i   (req_i.string_length),
  .start_of_string_i (req_i.start_of_string),
  .out_valid_i       (res_o.valid),
  .out_ready_i       (res_o.ready),
  .hash_value_i      (res_o.hash_value)
);

### sim/shapt_hash_checker.sv
`timescale 1ns / 1ps
// Checker of the string hash unit: watches the request and result channels,
// predicts each hash from the accepted bytes and compares it with the result.
// Depends on shapt_pkg and the channel interfaces in shapt_ifs.
module shapt_hash_checker
  import shapt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  shapt_in_if         req_i,
  shapt_out_if        res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Predicted state of the hash.
  logic [31:0] mix_a = '0;
  logic [31:0] mix_b = '0;
  logic [31:0] mix_h = '0;
  logic [31:0] remaining = '0;
  logic [7:0]  chunk_buf [CHUNK_BYTES];
  logic [7:0]  tail_buf [TAIL_DEPTH];
  int unsigned chunk_pos = 0;
  int unsigned tail_cnt = 0;
  logic        in_str = 1'b0;

  logic [31:0] hash_expected_q [$];
  logic [31:0] want_hash;
  int unsigned n_fails = 0;
  int unsigned n_pending = 0;

  assign fail_count_o = n_fails;
  assign pending_o    = n_pending;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned s);
    return (x >> s) | (x << (32 - s));
  endfunction

  // Add one 12-byte chunk as three little-endian words, then mix.
  task automatic absorb_chunk();
    mix_a += {chunk_buf[3], chunk_buf[2], chunk_buf[1], chunk_buf[0]};
    mix_b += {chunk_buf[7], chunk_buf[6], chunk_buf[5], chunk_buf[4]};
    mix_h += {chunk_buf[11], chunk_buf[10], chunk_buf[9], chunk_buf[8]};
    mix_a ^= mix_h;
    mix_a -= ror32(mix_h, ROT_A);
    mix_b ^= mix_a;
    mix_b -= ror32(mix_a, ROT_B);
    mix_h ^= mix_b;
    mix_h -= ror32(mix_b, ROT_H);
  endtask

  // Advance the prediction by one accepted request.
  task automatic hash_step(input logic [7:0] b, input logic [31:0] len, input logic sos);
    logic [31:0] h;
    if (sos) begin
      mix_a     = '0;
      mix_b     = '0;
      mix_h     = len;
      remaining = len;
      chunk_pos = 0;
      tail_cnt  = 0;
      // An empty string hashes to its length, zero, at once.
      if (len == '0) begin
        in_str = 1'b0;
        hash_expected_q.push_back(len);
        return;
      end
      in_str = 1'b1;
    end else if (!in_str) begin
      // A stray byte outside any string is dropped.
      return;
    end

    if (chunk_pos != 0 || (tail_cnt == 0 && remaining >= PREFIX_MIN)) begin
      chunk_buf[chunk_pos] = b;
      chunk_pos++;
      if (chunk_pos >= CHUNK_BYTES) begin
        absorb_chunk();
        chunk_pos = 0;
      end
    end else if (tail_cnt < TAIL_DEPTH) begin
      tail_buf[tail_cnt] = b;
      tail_cnt++;
    end

    remaining--;
    if (remaining != '0) return;

    // Fold the tail in from the last byte to the first.
    h = mix_h;
    for (int i = tail_cnt; i > 0; i--) begin
      h ^= (h << FOLD_SHL) + (h >> FOLD_SHR) + {24'd0, tail_buf[i - 1]};
    end
    mix_h  = h;
    in_str = 1'b0;
    hash_expected_q.push_back(mix_h);
  endtask

  // Compare results first: the result is registered, so a hash leaves the block only after
  // the request that caused it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_a     = '0;
      mix_b     = '0;
      mix_h     = '0;
      remaining = '0;
      chunk_pos = 0;
      tail_cnt  = 0;
      in_str    = 1'b0;
      hash_expected_q.delete();
      n_pending = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (hash_expected_q.size() == 0) begin
          $display("%0t: unexpected hash, expected none, actual %08h",
                   $time, res_i.hash_value);
          n_fails++;
        end else begin
          want_hash = hash_expected_q.pop_front();
          if (res_i.hash_value !== want_hash) begin
            $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                     $time, want_hash, res_i.hash_value);
            n_fails++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        hash_step(req_i.data_byte, req_i.string_length, req_i.start_of_string);
      end
      n_pending = hash_expected_q.size();
    end
  end

endmodule

### sim/string_hash_arx_prefix_tail_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top of the string hash unit: clock, reset, byte-string stimulus,
// result back-pressure and the verdict. Depends on shapt_pkg, shapt_ifs,
// the unit itself and shapt_hash_checker.
module string_hash_arx_prefix_tail_unit_tb;
  import shapt_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_ITEMS   = 225;
  localparam int unsigned DRAIN_CYCLES  = 64;

  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  shapt_in_if  req_if ();
  shapt_out_if res_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_off_req = 1'b0;

  string_hash_arx_prefix_tail_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  shapt_hash_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog on the cycle count.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        res_if.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one request from a falling edge and return at the falling edge
  // after it was taken.
  task automatic send_req(input logic [7:0] b, input logic [31:0] len, input logic sos);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid           = 1'b1;
    req_if.data_byte       = b;
    req_if.string_length   = len;
    req_if.start_of_string = sos;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  function automatic logic [7:0] fill_byte(input fill_e fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom);
    endcase
  endfunction

  // Send the first nbytes of a string of length len; nbytes < len abandons it.
  task automatic send_string(input logic [31:0] len, input int unsigned nbytes,
                             input fill_e fill);
    send_req(fill_byte(fill), len, 1'b1);
    for (int unsigned i = 1; i < nbytes; i++) begin
      send_req(fill_byte(fill), $urandom, 1'b0);
    end
  endtask

  // One random string, mostly well formed, some abandoned, some stray bytes.
  task automatic send_random_string();
    int unsigned pick;
    int unsigned nbytes;
    logic [31:0] len;
    int unsigned edges [8] = '{31, 32, 33, 43, 44, 45, 55, 56};
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_string('0, 1, FILL_RANDOM);
    end else if (pick < 35) begin
      len = $urandom_range(1, 31);
      send_string(len, len, FILL_RANDOM);
    end else if (pick < 72) begin
      len = $urandom_range(32, 80);
      send_string(len, len, FILL_RANDOM);
    end else if (pick < 78) begin
      len = $urandom_range(81, 160);
      send_string(len, len, FILL_RANDOM);
    end else if (pick < 90) begin
      nbytes = $urandom_range(1, 40);
      len = $urandom;
      if (len <= nbytes) len = nbytes + 1;
      send_string(len, nbytes, FILL_RANDOM);
    end else if (pick < 95) begin
      nbytes = $urandom_range(1, 3);
      for (int unsigned i = 0; i < nbytes; i++) begin
        send_req(8'($urandom), $urandom, 1'b0);
      end
    end else begin
      len = edges[$urandom_range(0, 7)];
      send_string(len, len, FILL_RANDOM);
    end
  endtask

  // Reset, directed strings, random phases, drain and verdict.
  initial begin
    int unsigned phase_end;
    req_if.valid           = 1'b0;
    req_if.data_byte       = '0;
    req_if.string_length   = '0;
    req_if.start_of_string = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: stray byte, empty string, shortest strings, abandoned
    // string of maximum length, and the chunk boundary with all-ones bytes.
    send_req(8'hFF, 32'hFFFF_FFFF, 1'b0);
    send_string('0, 1, FILL_ONES);
    send_string(32'd1, 1, FILL_ONES);
    send_string(32'd2, 2, FILL_ZERO);
    send_string(32'hFFFF_FFFF, 3, FILL_ONES);
    send_string(32'd31, 31, FILL_ONES);
    send_string(32'd32, 32, FILL_ONES);
    send_string('0, 1, FILL_ZERO);

    // Random part in phases of sender idling and receiver stalls.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_off_req = 1'b1; end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_random_string();
    end
    idle_pct = 0;
    // Close any abandoned string so the block settles.
    send_string(32'd5, 5, FILL_RANDOM);

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
